[design/ps2kt_pkg.sv]
// shared types, codes and scan-code tables of the ps/2 key tracker
package ps2kt_pkg;

   localparam int SET_DEPTH_DEF = 16;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [7:0] SC_BREAK = 8'hf0;
   localparam logic [7:0] SC_EXT0  = 8'he0;
   localparam logic [7:0] SC_EXT1  = 8'he1;

   localparam logic [2:0] EV_NONE   = 3'd0;
   localparam logic [2:0] EV_MOD    = 3'd1;
   localparam logic [2:0] EV_ADD    = 3'd2;
   localparam logic [2:0] EV_REMOVE = 3'd3;
   localparam logic [2:0] EV_QUERY  = 3'd4;

   localparam logic [5:0] MOD_ALTL   = 6'h01;
   localparam logic [5:0] MOD_ALTR   = 6'h02;
   localparam logic [5:0] MOD_CTRLL  = 6'h04;
   localparam logic [5:0] MOD_CTRLR  = 6'h08;
   localparam logic [5:0] MOD_SHIFTL = 6'h10;
   localparam logic [5:0] MOD_SHIFTR = 6'h20;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_MAKE  = 2'd1,
      OP_BREAK = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       right;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] code;
   } xlat_type;

   function automatic logic [5:0] modifier_mask(input logic [7:0] sc, input logic right);
      logic [5:0] m;
      m = 6'h00;
      priority if (sc == 8'h11) m = right ? MOD_ALTR : MOD_ALTL;
      else if (sc == 8'h14) m = right ? MOD_CTRLR : MOD_CTRLL;
      else if (sc == 8'h12) m = MOD_SHIFTL;
      else if (sc == 8'h59) m = MOD_SHIFTR;
      else m = 6'h00;
      return m;
   endfunction

   function automatic xlat_type translate(input logic [7:0] sc, input logic [5:0] mods);
      logic sh;
      logic ar;
      xlat_type t;
      sh = |(mods & (MOD_SHIFTL | MOD_SHIFTR));
      ar = |(mods & MOD_ALTR);
      t.valid = 1'b1;
      unique case (sc)
         8'h5a: t.code = 6'd0;
         8'h1c: t.code = 6'd1;
         8'h32: t.code = 6'd2;
         8'h21: t.code = 6'd3;
         8'h23: t.code = 6'd4;
         8'h24: t.code = 6'd5;
         8'h2b: t.code = 6'd6;
         8'h34: t.code = 6'd7;
         8'h33: t.code = 6'd8;
         8'h43: t.code = 6'd9;
         8'h3b: t.code = 6'd10;
         8'h42: t.code = 6'd11;
         8'h4b: t.code = 6'd12;
         8'h3a: t.code = 6'd13;
         8'h31: t.code = 6'd14;
         8'h44: t.code = 6'd15;
         8'h4d: t.code = 6'd16;
         8'h15: t.code = 6'd17;
         8'h2d: t.code = 6'd18;
         8'h1b: t.code = 6'd19;
         8'h2c: t.code = 6'd20;
         8'h3c: t.code = 6'd21;
         8'h2a: t.code = 6'd22;
         8'h1d: t.code = 6'd23;
         8'h22: t.code = 6'd24;
         8'h35: t.code = 6'd25;
         8'h1a: t.code = 6'd26;
         8'h29: t.code = 6'd27;
         8'h3e: t.code = ar ? 6'd28 : (sh ? 6'd29 : 6'd30);
         8'h46: t.code = ar ? 6'd31 : (sh ? 6'd32 : 6'd33);
         8'h16: t.code = sh ? 6'd34 : 6'd35;
         8'h1e: t.code = sh ? 6'd36 : 6'd37;
         8'h5d: t.code = sh ? 6'd38 : 6'd39;
         8'h2e: t.code = sh ? 6'd42 : 6'd43;
         8'h36: t.code = sh ? 6'd44 : 6'd45;
         8'h5b: t.code = sh ? 6'd46 : 6'd47;
         8'h41: t.code = sh ? 6'd48 : 6'd49;
         8'h4a: t.code = 6'd50;
         8'h49: t.code = sh ? 6'd57 : 6'd51;
         8'h3d: t.code = sh ? 6'd52 : 6'd53;
         8'h45: t.code = sh ? 6'd54 : 6'd55;
         8'h26: t.code = 6'd56;
         8'h61: t.code = sh ? 6'd58 : 6'd59;
         8'h4e: t.code = 6'd60;
         default: begin
            t.valid = 1'b0;
            t.code  = 6'd0;
         end
      endcase
      return t;
   endfunction

endpackage

[design/ps2_scancode_key_tracker_top.sv]
// top level of the ps/2 set-2 scan-code key tracker
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_kind, req_data
//   rsp      out        rsp_valid/rsp_stall   rsp_event_res, rsp_code, rsp_modifier_bits,
//                                             rsp_held_count, rsp_is_down
//
// a request, once accepted, waits in the queue while the back end loads it, then passes
// its lookup and apply steps, and the apply step registers its response; the back end
// sequencer takes no new request until the last one is applied, and its apply step waits
// while a stalled response is still held; while a response waits on rsp_stall the queue
// holds up to 2 further requests, then req_stall rises
// synchronous active-high reset clears prefix state, modifiers, set count and queue
module ps2_scancode_key_tracker_top #(
   parameter int SET_DEPTH = ps2kt_pkg::SET_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [5:0] rsp_code,
   output logic [5:0] rsp_modifier_bits,
   output logic [4:0] rsp_held_count,
   output logic       rsp_is_down
);

   logic               push_valid;
   logic               push_ready;
   ps2kt_pkg::cmd_type push_cmd;
   logic               pop_valid;
   logic               pop_ready;
   ps2kt_pkg::cmd_type pop_cmd;

   assign req_stall = !push_ready;

   ps2kt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_kind   (req_kind),
      .req_data   (req_data),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   ps2kt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   ps2kt_back #(
      .SET_DEPTH (SET_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_cmd           (pop_cmd),
      .pop_ready         (pop_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_code          (rsp_code),
      .rsp_modifier_bits (rsp_modifier_bits),
      .rsp_held_count    (rsp_held_count),
      .rsp_is_down       (rsp_is_down)
   );

endmodule

[design/ps2kt_front.sv]
// front end: prefix machine that turns bytes and queries into commands
module ps2kt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   input  logic [7:0]          req_data,
   input  logic                push_ready,
   output logic                push_valid,
   output ps2kt_pkg::cmd_type  push_cmd
);

   typedef enum logic [5:0] {
      PS_ANY   = 6'b000001,
      PS_E0    = 6'b000010,
      PS_E1    = 6'b000100,
      PS_BRK   = 6'b001000,
      PS_BRKE0 = 6'b010000,
      PS_BRKE1 = 6'b100000
   } pstate_type;

   pstate_type pstate_ff, pstate_in;
   ps2kt_pkg::cmd_type cmd;

   assign push_valid = req_valid;
   assign push_cmd   = cmd;

   always_comb begin
      cmd.op    = ps2kt_pkg::OP_NONE;
      cmd.right = 1'b0;
      cmd.data  = req_data;
      pstate_in = PS_ANY;
      if (req_kind) begin
         cmd.op    = ps2kt_pkg::OP_QUERY;
         pstate_in = pstate_ff;
      end else begin
         unique case (pstate_ff)
            PS_E0: begin
               if (req_data == ps2kt_pkg::SC_BREAK) begin
                  pstate_in = PS_BRKE0;
               end else begin
                  cmd.op    = ps2kt_pkg::OP_MAKE;
                  cmd.right = 1'b1;
               end
            end
            PS_E1: begin
               if (req_data == ps2kt_pkg::SC_BREAK) begin
                  pstate_in = PS_BRKE1;
               end else begin
                  cmd.op = ps2kt_pkg::OP_MAKE;
               end
            end
            PS_BRK, PS_BRKE1: begin
               cmd.op = ps2kt_pkg::OP_BREAK;
            end
            PS_BRKE0: begin
               cmd.op    = ps2kt_pkg::OP_BREAK;
               cmd.right = 1'b1;
            end
            default: begin
               priority if (req_data == ps2kt_pkg::SC_BREAK) pstate_in = PS_BRK;
               else if (req_data == ps2kt_pkg::SC_EXT0) pstate_in = PS_E0;
               else if (req_data == ps2kt_pkg::SC_EXT1) pstate_in = PS_E1;
               else cmd.op = ps2kt_pkg::OP_MAKE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pstate_ff <= PS_ANY;
      end else if (req_valid && push_ready) begin
         pstate_ff <= pstate_in;
      end
   end

endmodule

[design/ps2kt_queue.sv]
// small command queue between the front end and the back end
module ps2kt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  ps2kt_pkg::cmd_type  push_cmd,
   output logic                push_ready,
   output logic                pop_valid,
   output ps2kt_pkg::cmd_type  pop_cmd,
   input  logic                pop_ready
);

   localparam int PW = (ps2kt_pkg::QUEUE_DEPTH > 1) ? $clog2(ps2kt_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(ps2kt_pkg::QUEUE_DEPTH + 1);

   ps2kt_pkg::cmd_type entry_ff [ps2kt_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          do_push;
   logic          do_pop;

   assign push_ready = (fill_ff != CW'(ps2kt_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(ps2kt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(ps2kt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[design/ps2kt_back.sv]
// back end: modifiers, translation, held-key set and response register
module ps2kt_back #(
   parameter int SET_DEPTH = ps2kt_pkg::SET_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   input  ps2kt_pkg::cmd_type  pop_cmd,
   output logic                pop_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_event_res,
   output logic [5:0]          rsp_code,
   output logic [5:0]          rsp_modifier_bits,
   output logic [4:0]          rsp_held_count,
   output logic                rsp_is_down
);

   localparam int CW = $clog2(SET_DEPTH + 1);

   typedef enum logic [2:0] {
      BS_IDLE  = 3'b001,
      BS_LOOK  = 3'b010,
      BS_APPLY = 3'b100
   } bstate_type;

   bstate_type          bstate_ff, bstate_in;
   ps2kt_pkg::cmd_type  cmd_ff, cmd_in;
   logic [5:0]          mods_ff, mods_in;
   logic [CW-1:0]       total_ff, total_in;
   logic [5:0]          held_ff [SET_DEPTH];
   logic [5:0]          key_ff, key_in;
   logic                key_ok_ff, key_ok_in;
   logic [5:0]          mask_ff, mask_in;
   logic [SET_DEPTH-1:0] match_ff, match_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          ev_ff, ev_in;
   logic [5:0]          code_ff, code_in;
   logic                down_ff, down_in;

   ps2kt_pkg::xlat_type xl;
   logic                 out_free;
   logic                 hit;
   logic                 add_en;
   logic                 rm_en;
   logic [SET_DEPTH-1:0] from_vec;
   logic                 acc;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop_ready = (bstate_ff == BS_IDLE);
   assign hit       = |match_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = ev_ff;
   assign rsp_code          = code_ff;
   assign rsp_modifier_bits = mods_ff;
   assign rsp_held_count    = 5'(total_ff);
   assign rsp_is_down       = down_ff;

   always_comb begin
      xl = ps2kt_pkg::translate(cmd_ff.data, mods_ff);
      mask_in = ps2kt_pkg::modifier_mask(cmd_ff.data, cmd_ff.right);
      if (cmd_ff.op == ps2kt_pkg::OP_QUERY) begin
         key_in    = cmd_ff.data[5:0];
         key_ok_in = (cmd_ff.data[7:6] == 2'b00);
      end else begin
         key_in    = xl.code;
         key_ok_in = xl.valid;
      end
      for (int i = 0; i < SET_DEPTH; i++) begin
         match_in[i] = (CW'(i) < total_ff) && (held_ff[i] == key_in);
      end
      acc = 1'b0;
      for (int i = 0; i < SET_DEPTH; i++) begin
         acc         = acc | match_ff[i];
         from_vec[i] = acc;
      end
   end

   always_comb begin
      bstate_in    = bstate_ff;
      cmd_in       = cmd_ff;
      mods_in      = mods_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ev_in        = ev_ff;
      code_in      = code_ff;
      down_in      = down_ff;
      add_en       = 1'b0;
      rm_en        = 1'b0;
      unique case (bstate_ff)
         BS_IDLE: begin
            if (pop_valid) begin
               cmd_in    = pop_cmd;
               bstate_in = BS_LOOK;
            end
         end
         BS_LOOK: begin
            bstate_in = BS_APPLY;
         end
         BS_APPLY: begin
            if (out_free) begin
               bstate_in    = BS_IDLE;
               rsp_valid_in = 1'b1;
               ev_in        = ps2kt_pkg::EV_NONE;
               code_in      = 6'd0;
               down_in      = 1'b0;
               unique case (cmd_ff.op)
                  ps2kt_pkg::OP_QUERY: begin
                     ev_in   = ps2kt_pkg::EV_QUERY;
                     down_in = key_ok_ff && hit;
                  end
                  ps2kt_pkg::OP_MAKE: begin
                     priority if (mask_ff != 6'd0) begin
                        mods_in = mods_ff | mask_ff;
                        ev_in   = (mods_in != mods_ff) ? ps2kt_pkg::EV_MOD : ps2kt_pkg::EV_NONE;
                     end else if (key_ok_ff && (total_ff < CW'(SET_DEPTH)) && !hit) begin
                        add_en   = 1'b1;
                        total_in = total_ff + 1'b1;
                        ev_in    = ps2kt_pkg::EV_ADD;
                        code_in  = key_ff;
                     end
                  end
                  ps2kt_pkg::OP_BREAK: begin
                     priority if (mask_ff != 6'd0) begin
                        mods_in = mods_ff & ~mask_ff;
                        ev_in   = (mods_in != mods_ff) ? ps2kt_pkg::EV_MOD : ps2kt_pkg::EV_NONE;
                     end else if (key_ok_ff && hit) begin
                        rm_en    = 1'b1;
                        total_in = total_ff - 1'b1;
                        ev_in    = ps2kt_pkg::EV_REMOVE;
                        code_in  = key_ff;
                     end
                  end
                  default: begin
                     ev_in = ps2kt_pkg::EV_NONE;
                  end
               endcase
            end
         end
         default: begin
            bstate_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff    <= BS_IDLE;
         mods_ff      <= 6'd0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bstate_ff    <= bstate_in;
         mods_ff      <= mods_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      ev_ff     <= ev_in;
      code_ff   <= code_in;
      down_ff   <= down_in;
      if (bstate_ff == BS_LOOK) begin
         key_ff    <= key_in;
         key_ok_ff <= key_ok_in;
         mask_ff   <= mask_in;
         match_ff  <= match_in;
      end
      for (int i = 0; i < SET_DEPTH; i++) begin
         if (add_en && (total_ff == CW'(i))) begin
            held_ff[i] <= key_ff;
         end else if (rm_en && from_vec[i] && (i < SET_DEPTH - 1)) begin
            held_ff[i] <= held_ff[(i < SET_DEPTH - 1) ? i + 1 : i];
         end
      end
   end

endmodule

[design/ps2kt_checker.sv]
// port-level checker for the key tracker and its bind
module ps2kt_checker #(
   parameter int SET_DEPTH = ps2kt_pkg::SET_DEPTH_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_event_res,
   input logic [5:0] rsp_code,
   input logic [4:0] rsp_held_count,
   input logic       rsp_is_down
);

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res <= ps2kt_pkg::EV_QUERY)
      else $error("event code out of range");

   a_down_only_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != ps2kt_pkg::EV_QUERY) |-> !rsp_is_down)
      else $error("is_down set on a non-query response");

   a_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res != ps2kt_pkg::EV_ADD)
                && (rsp_event_res != ps2kt_pkg::EV_REMOVE) |-> rsp_code == 6'd0)
      else $error("code set on a response without a key change");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (SET_DEPTH < 32) |-> int'(rsp_held_count) <= SET_DEPTH)
      else $error("held count above set depth");

endmodule

bind ps2_scancode_key_tracker_top ps2kt_checker #(
   .SET_DEPTH (SET_DEPTH)
) u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_event_res  (rsp_event_res),
   .rsp_code       (rsp_code),
   .rsp_held_count (rsp_held_count),
   .rsp_is_down    (rsp_is_down)
);

[verif/ps2_scancode_key_tracker_top_tb.sv]
// testbench for the ps/2 set-2 key tracker: scan-code traffic against a self-checking scoreboard
`timescale 1ns / 1ps

module ps2_scancode_key_tracker_top_tb;

   localparam int   SET_DEPTH      = ps2kt_pkg::SET_DEPTH_DEF;
   localparam int   WATCHDOG_LIMIT = 1000;
   localparam int   HOLD_CYCLES    = 60;
   localparam int   PHASE_ITEMS    = 570;
   localparam logic KIND_BYTE      = 1'b0;
   localparam logic KIND_QUERY     = 1'b1;

   // mapped key scan codes; the first 28 translate to 0..27 whatever the modifiers
   localparam logic [8*44-1:0] KEY_SCANS = {
      8'h5a, 8'h1c, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2b, 8'h34, 8'h33, 8'h43, 8'h3b,
      8'h42, 8'h4b, 8'h3a, 8'h31, 8'h44, 8'h4d, 8'h15, 8'h2d, 8'h1b, 8'h2c, 8'h3c,
      8'h2a, 8'h1d, 8'h22, 8'h35, 8'h1a, 8'h29, 8'h3e, 8'h46, 8'h16, 8'h1e, 8'h5d,
      8'h2e, 8'h36, 8'h5b, 8'h41, 8'h4a, 8'h49, 8'h3d, 8'h45, 8'h26, 8'h61, 8'h4e
   };
   localparam logic [31:0] MOD_SCANS = {8'h11, 8'h14, 8'h12, 8'h59};

   typedef enum logic [5:0] {
      PFX_IDLE     = 6'b000001,
      PFX_EXT0     = 6'b000010,
      PFX_EXT1     = 6'b000100,
      PFX_BRK      = 6'b001000,
      PFX_BRK_EXT0 = 6'b010000,
      PFX_BRK_EXT1 = 6'b100000
   } pfx_state_type;

   typedef struct {
      logic [2:0] ev;
      logic [5:0] code;
      logic [5:0] mods;
      logic [4:0] count;
      logic       down;
   } key_event_type;

   function automatic logic [7:0] key_scan_at(int idx);
      return KEY_SCANS[8*(43-idx) +: 8];
   endfunction

   class key_tracker_scoreboard;
      pfx_state_type pfx;
      logic [5:0]    mods;
      logic [5:0]    held[$];
      key_event_type pending[$];
      int            depth;
      int            errors;

      function new(int set_depth);
         depth  = set_depth;
         pfx    = PFX_IDLE;
         mods   = 6'h00;
         errors = 0;
      endfunction

      function int held_index(int c);
         foreach (held[i]) begin
            if (held[i] == c) return i;
         end
         return -1;
      endfunction

      function logic [5:0] modifier_bit(logic [7:0] sc, logic right);
         case (sc)
            8'h11: return right ? ps2kt_pkg::MOD_ALTR : ps2kt_pkg::MOD_ALTL;
            8'h14: return right ? ps2kt_pkg::MOD_CTRLR : ps2kt_pkg::MOD_CTRLL;
            8'h12: return ps2kt_pkg::MOD_SHIFTL;
            8'h59: return ps2kt_pkg::MOD_SHIFTR;
            default: return 6'h00;
         endcase
      endfunction

      function int char_of_scan(logic [7:0] sc, logic [5:0] m);
         logic sh;
         logic ar;
         sh = |(m & (ps2kt_pkg::MOD_SHIFTL | ps2kt_pkg::MOD_SHIFTR));
         ar = |(m & ps2kt_pkg::MOD_ALTR);
         for (int i = 0; i < 28; i++) begin
            if (key_scan_at(i) == sc) return i;
         end
         case (sc)
            8'h3e: return ar ? 28 : (sh ? 29 : 30);
            8'h46: return ar ? 31 : (sh ? 32 : 33);
            8'h16: return sh ? 34 : 35;
            8'h1e: return sh ? 36 : 37;
            8'h5d: return sh ? 38 : 39;
            8'h2e: return sh ? 42 : 43;
            8'h36: return sh ? 44 : 45;
            8'h5b: return sh ? 46 : 47;
            8'h41: return sh ? 48 : 49;
            8'h4a: return 50;
            8'h49: return sh ? 57 : 51;
            8'h3d: return sh ? 52 : 53;
            8'h45: return sh ? 54 : 55;
            8'h26: return 56;
            8'h61: return sh ? 58 : 59;
            8'h4e: return 60;
            default: return -1;
         endcase
      endfunction

      function void key_make(logic [7:0] sc, logic right, inout key_event_type e);
         logic [5:0] m;
         logic [5:0] prev_mods;
         int         c;
         m = modifier_bit(sc, right);
         if (m != 6'h00) begin
            prev_mods = mods;
            mods = mods | m;
            if (mods != prev_mods) e.ev = ps2kt_pkg::EV_MOD;
            return;
         end
         c = char_of_scan(sc, mods);
         if (c < 0 || held.size() >= depth || held_index(c) >= 0) return;
         held.push_back(6'(c));
         e.ev   = ps2kt_pkg::EV_ADD;
         e.code = 6'(c);
      endfunction

      function void key_break(logic [7:0] sc, logic right, inout key_event_type e);
         logic [5:0] m;
         logic [5:0] prev_mods;
         int         c;
         int         pos;
         m = modifier_bit(sc, right);
         if (m != 6'h00) begin
            prev_mods = mods;
            mods = mods & ~m;
            if (mods != prev_mods) e.ev = ps2kt_pkg::EV_MOD;
            return;
         end
         c = char_of_scan(sc, mods);
         if (c < 0) return;
         pos = held_index(c);
         if (pos < 0) return;
         held.delete(pos);
         e.ev   = ps2kt_pkg::EV_REMOVE;
         e.code = 6'(c);
      endfunction

      function void note_request(logic kind, logic [7:0] data);
         key_event_type e;
         pfx_state_type nxt;
         e.ev   = ps2kt_pkg::EV_NONE;
         e.code = 6'd0;
         e.down = 1'b0;
         if (kind == KIND_QUERY) begin
            e.ev   = ps2kt_pkg::EV_QUERY;
            e.down = (data <= 8'd63) && (held_index(data) >= 0);
         end else begin
            nxt = PFX_IDLE;
            case (pfx)
               PFX_EXT0: begin
                  if (data == ps2kt_pkg::SC_BREAK) nxt = PFX_BRK_EXT0;
                  else key_make(data, 1'b1, e);
               end
               PFX_EXT1: begin
                  if (data == ps2kt_pkg::SC_BREAK) nxt = PFX_BRK_EXT1;
                  else key_make(data, 1'b0, e);
               end
               PFX_BRK, PFX_BRK_EXT1: key_break(data, 1'b0, e);
               PFX_BRK_EXT0: key_break(data, 1'b1, e);
               default: begin
                  if (data == ps2kt_pkg::SC_BREAK) nxt = PFX_BRK;
                  else if (data == ps2kt_pkg::SC_EXT0) nxt = PFX_EXT0;
                  else if (data == ps2kt_pkg::SC_EXT1) nxt = PFX_EXT1;
                  else key_make(data, 1'b0, e);
               end
            endcase
            pfx = nxt;
         end
         e.mods  = mods;
         e.count = 5'(held.size());
         pending.push_back(e);
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] seen);
         if (seen !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_response(key_event_type got);
         key_event_type want;
         if (pending.size() == 0) begin
            $display("%0t: response with no request waiting, expected none, actual event %0d",
                     $time, got.ev);
            errors++;
            return;
         end
         want = pending.pop_front();
         check_field("event_res", 8'(want.ev), 8'(got.ev));
         check_field("code", 8'(want.code), 8'(got.code));
         check_field("modifier_bits", 8'(want.mods), 8'(got.mods));
         check_field("held_count", 8'(want.count), 8'(got.count));
         check_field("is_down", 8'(want.down), 8'(got.down));
      endfunction
   endclass

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic       req_kind    = 1'b0;
   logic [7:0] req_data    = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [2:0] rsp_event_res;
   logic [5:0] rsp_code;
   logic [5:0] rsp_modifier_bits;
   logic [4:0] rsp_held_count;
   logic       rsp_is_down;

   key_tracker_scoreboard sb;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         items_sent    = 0;
   int         idle_cycles   = 0;
   int         hold_left     = 0;
   bit         hold_request  = 1'b0;
   logic [7:0] pressed_scans[$];

   ps2_scancode_key_tracker_top #(.SET_DEPTH(SET_DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_code         (rsp_code),
      .rsp_modifier_bits(rsp_modifier_bits),
      .rsp_held_count   (rsp_held_count),
      .rsp_is_down      (rsp_is_down)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      key_event_type got;
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_kind, req_data);
         if (rsp_valid && !rsp_stall) begin
            got.ev    = rsp_event_res;
            got.code  = rsp_code;
            got.mods  = rsp_modifier_bits;
            got.count = rsp_held_count;
            got.down  = rsp_is_down;
            sb.check_response(got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("** ps2_scancode_key_tracker_top: FAILED **");
            $finish;
         end
      end
   end

   task automatic drive_request(input logic kind, input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_data  <= data;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] data);
      drive_request(KIND_BYTE, data);
   endtask

   task automatic send_query(input logic [7:0] data);
      drive_request(KIND_QUERY, data);
   endtask

   task automatic wait_for_drain;
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [7:0] pick_key_scan();
      return key_scan_at($urandom_range(43));
   endfunction

   task automatic press_key(input logic [7:0] sc);
      send_byte(sc);
      pressed_scans.push_back(sc);
      if (pressed_scans.size() > 24) void'(pressed_scans.pop_front());
   endtask

   task automatic play_random_group;
      int         r;
      int         idx;
      int         p;
      logic [7:0] sc;
      r = $urandom_range(99);
      if (r < 3) begin
         repeat ($urandom_range(12, 20)) press_key(pick_key_scan());
      end else if (r < 6) begin
         while (pressed_scans.size() != 0) begin
            send_byte(ps2kt_pkg::SC_BREAK);
            send_byte(pressed_scans.pop_back());
         end
      end else if (r < 34) begin
         if ($urandom_range(9) == 0) send_byte(ps2kt_pkg::SC_EXT0);
         press_key(pick_key_scan());
      end else if (r < 54) begin
         if (pressed_scans.size() != 0 && $urandom_range(9) < 7) begin
            idx = $urandom_range(pressed_scans.size() - 1);
            sc  = pressed_scans[idx];
            pressed_scans.delete(idx);
         end else begin
            sc = pick_key_scan();
         end
         p = $urandom_range(19);
         if (p < 3) send_byte(ps2kt_pkg::SC_EXT0);
         else if (p == 3) send_byte(ps2kt_pkg::SC_EXT1);
         send_byte(ps2kt_pkg::SC_BREAK);
         send_byte(sc);
      end else if (r < 66) begin
         sc = MOD_SCANS[8*$urandom_range(3) +: 8];
         if ($urandom_range(1) == 1) send_byte(ps2kt_pkg::SC_EXT0);
         if ($urandom_range(1) == 1) send_byte(ps2kt_pkg::SC_BREAK);
         send_byte(sc);
      end else if (r < 80) begin
         if (sb.held.size() != 0 && $urandom_range(1) == 1)
            send_query(8'(sb.held[$urandom_range(sb.held.size() - 1)]));
         else if ($urandom_range(9) == 0)
            send_query(8'($urandom_range(255)));
         else
            send_query(8'($urandom_range(63)));
      end else if (r < 86) begin
         send_byte(ps2kt_pkg::SC_EXT1);
         if ($urandom_range(1) == 1) send_byte(pick_key_scan());
         else send_byte(8'($urandom_range(255)));
      end else begin
         send_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      int  target;
      bit  hold_done;
      bit  pause_done;
      sb = new(SET_DEPTH);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, prefixes, modifiers and the corner cases
      send_query(8'h00);
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(ps2kt_pkg::SC_EXT0);
      send_byte(8'h11);
      send_byte(8'h11);
      send_byte(8'h11);
      send_byte(ps2kt_pkg::SC_EXT0);
      send_byte(8'h14);
      send_byte(8'h59);
      send_byte(8'h3e);
      send_byte(8'h3e);
      send_byte(8'h16);
      send_byte(ps2kt_pkg::SC_BREAK);
      send_byte(8'h59);
      send_byte(ps2kt_pkg::SC_BREAK);
      send_byte(8'h16);
      send_query(8'd34);
      send_query(8'd63);
      send_query(8'hff);
      send_byte(ps2kt_pkg::SC_BREAK);
      send_byte(ps2kt_pkg::SC_BREAK);
      send_byte(ps2kt_pkg::SC_EXT0);
      send_byte(ps2kt_pkg::SC_EXT1);
      send_byte(ps2kt_pkg::SC_EXT1);
      send_byte(ps2kt_pkg::SC_BREAK);
      send_byte(8'h14);
      send_byte(ps2kt_pkg::SC_EXT0);
      send_byte(ps2kt_pkg::SC_BREAK);
      send_byte(8'h11);
      wait_for_drain();

      hold_done  = 1'b0;
      pause_done = 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 29; recv_idle_pct = 52; end
            1: begin send_idle_pct = 52; recv_idle_pct = 29; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            play_random_group();
            if (!hold_done && items_sent > target - 300) begin
               hold_request = 1'b1;
               hold_done    = 1'b1;
            end
            if (phase == 1 && !pause_done && items_sent > target - 300) begin
               wait_for_drain();
               pause_done = 1'b1;
            end
         end
         wait_for_drain();
      end

      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("** ps2_scancode_key_tracker_top: PASSED **");
      end else begin
         $display("** ps2_scancode_key_tracker_top: FAILED **");
      end
      $finish;
   end

endmodule
